### rtl/sfs_pkg.sv
// Sprite frame sequencer package: widths, command kinds, play modes and
// configuration register indexes shared by the interfaces and the RTL.
// No dependencies.
`default_nettype none

package sfs_pkg;

    localparam int MAX_FRAMES_DEF = 64;

    localparam int KIND_W     = 3;
    localparam int DELTA_W    = 16;
    localparam int FRAME_W    = 6;
    localparam int DUR_W      = 16;
    localparam int MODE_W     = 2;
    localparam int COUNT_W    = 7;
    localparam int SPEED_W    = 16;
    localparam int ELAPSED_W  = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int CLIP_LIMIT = 64;

    localparam logic [COUNT_W-1:0]    FRAME_COUNT_RST = 7'd1;
    localparam logic [SPEED_W-1:0]    SPEED_RST       = 16'd256;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK      = 3'd0,
        KIND_PLAY      = 3'd1,
        KIND_PLAY_FROM = 3'd2,
        KIND_REVERSE   = 3'd3,
        KIND_STOP      = 3'd4,
        KIND_RESUME    = 3'd5
    } t_kind;

    typedef enum logic [MODE_W-1:0] {
        MODE_ONCE      = 2'd0,
        MODE_LOOP      = 2'd1,
        MODE_REV_ONCE  = 2'd2,
        MODE_REV_LOOP  = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_COUNT = 2'd0,
        CFG_INIT_MODE   = 2'd1,
        CFG_SPEED       = 2'd2
    } t_cfg_idx;

endpackage

`default_nettype wire

### rtl/sfs_req_if.sv
// Request channel of the sprite frame sequencer: valid, ready and one command.
// Depends on sfs_pkg.
`default_nettype none

interface sfs_req_if;
    import sfs_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [KIND_W-1:0]    kind;
    logic [DELTA_W-1:0]   delta;
    logic [FRAME_W-1:0]   start_frame;
    logic                 load_enable;
    logic [FRAME_W-1:0]   frame_index;
    logic [DUR_W-1:0]     frame_duration;

    modport source (
        output valid, kind, delta, start_frame, load_enable, frame_index, frame_duration,
        input  ready
    );

    modport sink (
        input  valid, kind, delta, start_frame, load_enable, frame_index, frame_duration,
        output ready
    );
endinterface

`default_nettype wire

### rtl/sfs_rsp_if.sv
// Response channel of the sprite frame sequencer: valid, ready and frame status.
// Depends on sfs_pkg.
`default_nettype none

interface sfs_rsp_if;
    import sfs_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [FRAME_W-1:0]   current_frame;
    logic                 playing;
    logic [MODE_W-1:0]    mode;
    logic                 frame_changed;

    modport source (
        output valid, current_frame, playing, mode, frame_changed,
        input  ready
    );

    modport sink (
        input  valid, current_frame, playing, mode, frame_changed,
        output ready
    );
endinterface

`default_nettype wire

### rtl/sprite_frame_sequencer_top.sv
// Sprite frame sequencer top level: command register, frame step logic,
// duration table and response register. Depends on sfs_pkg, sfs_req_if,
// sfs_rsp_if and sfs_dur_ram.
//
//   port      | dir | handshake     | carries
//   ----------+-----+---------------+-----------------------------------------
//   i_req     | in  | valid/ready   | kind, delta, start_frame, duration load
//   o_rsp     | out | valid/ready   | current_frame, playing, mode, changed
//   i_cfg_*   | in  | write enable  | frame_count, initial_mode, speed
//
// One request per cycle sustained while o_rsp is ready; each request passes
// through the command register and then the response register.
// The duration of the current frame is read ahead from the duration
// table, so a tick sees it without waiting. Reset clears control state
// only; table entries stay undefined until loaded. A stalled response
// holds the command register, which then holds i_req.ready low.
`default_nettype none

module sprite_frame_sequencer_top #(
    parameter int MAX_FRAMES = sfs_pkg::MAX_FRAMES_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    sfs_req_if.sink                             i_req,
    sfs_rsp_if.source                           o_rsp,
    input  wire logic                           i_cfg_we,
    input  wire logic [sfs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [sfs_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import sfs_pkg::*;

    localparam int ADDR_W   = $clog2(MAX_FRAMES);
    localparam int CLIP_MAX = (MAX_FRAMES < CLIP_LIMIT) ? MAX_FRAMES : CLIP_LIMIT;
    localparam logic [ELAPSED_W-1:0] ELAPSED_SAT = '1;

    // command register
    logic                 r_in_vld;
    logic [KIND_W-1:0]    r_kind;
    logic [DELTA_W-1:0]   r_delta;
    logic [FRAME_W-1:0]   r_start_frame;
    logic                 r_load;
    logic [FRAME_W-1:0]   r_frame_index;
    logic [DUR_W-1:0]     r_frame_duration;

    // sequencer state
    logic [COUNT_W-1:0]   r_frame_count;
    logic [SPEED_W-1:0]   r_speed;
    logic [FRAME_W-1:0]   r_frame_now;
    logic [FRAME_W-1:0]   r_frame_start;
    logic                 r_playing;
    t_mode                r_mode;
    logic [ELAPSED_W-1:0] r_elapsed;
    logic                 r_dur_oob;

    logic [FRAME_W-1:0]   n_frame_now;
    logic [FRAME_W-1:0]   n_frame_start;
    logic                 n_playing;
    t_mode                n_mode;
    logic [ELAPSED_W-1:0] n_elapsed;

    // response register
    logic                 r_out_vld;
    logic [FRAME_W-1:0]   r_out_frame;
    logic                 r_out_playing;
    t_mode                r_out_mode;
    logic                 r_out_changed;

    logic                 w_fire;
    logic [COUNT_W-1:0]   w_len;
    logic [COUNT_W-1:0]   w_last;
    logic [COUNT_W-1:0]   w_up;
    logic [COUNT_W-1:0]   w_down;
    logic [31:0]          w_prod;
    logic [32:0]          w_sum;
    logic [ELAPSED_W-1:0] w_elapsed;
    logic [DUR_W-1:0]     w_rd_data;
    logic [DUR_W-1:0]     w_dur;
    logic [FRAME_W-1:0]   w_step_frame;
    logic                 w_step_stop;
    logic [ADDR_W-1:0]    w_rd_addr;
    logic                 w_wr_en;

    assign w_fire      = r_in_vld && (!r_out_vld || o_rsp.ready);
    assign i_req.ready = !r_in_vld || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_req.valid && i_req.ready) begin
            r_in_vld <= 1'b1;
        end else if (w_fire) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_kind           <= i_req.kind;
            r_delta          <= i_req.delta;
            r_start_frame    <= i_req.start_frame;
            r_load           <= i_req.load_enable;
            r_frame_index    <= i_req.frame_index;
            r_frame_duration <= i_req.frame_duration;
        end
    end

    always_comb begin
        if (r_frame_count == '0) begin
            w_len = COUNT_W'(1);
        end else if (32'(r_frame_count) > CLIP_MAX) begin
            w_len = COUNT_W'(CLIP_MAX);
        end else begin
            w_len = r_frame_count;
        end
    end

    assign w_last = w_len - COUNT_W'(1);
    assign w_up   = {1'b0, r_frame_now} + COUNT_W'(1);
    assign w_down = {1'b0, r_frame_now} - COUNT_W'(1);

    // frame step on a finished duration
    always_comb begin
        w_step_frame = r_frame_now;
        w_step_stop  = 1'b0;
        unique case (r_mode)
            MODE_ONCE: begin
                if (w_up >= w_last) begin
                    w_step_frame = FRAME_W'((w_up > w_last) ? w_last : w_up);
                    w_step_stop  = 1'b1;
                end else begin
                    w_step_frame = FRAME_W'(w_up);
                end
            end
            MODE_LOOP: begin
                if (w_up >= w_len) begin
                    w_step_frame = r_frame_start;
                end else begin
                    w_step_frame = FRAME_W'(w_up);
                end
            end
            MODE_REV_ONCE: begin
                if (r_frame_now == '0) begin
                    w_step_stop = 1'b1;
                end else begin
                    w_step_frame = FRAME_W'(w_down);
                    w_step_stop  = (FRAME_W'(w_down) <= r_frame_start);
                end
            end
            MODE_REV_LOOP: begin
                if (r_frame_now == '0 || FRAME_W'(w_down) < r_frame_start) begin
                    w_step_frame = FRAME_W'(w_last);
                end else begin
                    w_step_frame = FRAME_W'(w_down);
                end
            end
            default: begin
                w_step_frame = r_frame_now;
            end
        endcase
    end

    assign w_prod    = 32'(r_delta) * 32'(r_speed);
    assign w_sum     = 33'(r_elapsed) + 33'(w_prod);
    assign w_elapsed = (w_sum > 33'(ELAPSED_SAT)) ? ELAPSED_SAT : w_sum[ELAPSED_W-1:0];
    assign w_dur     = r_dur_oob ? '0 : w_rd_data;

    always_comb begin
        n_frame_now   = r_frame_now;
        n_frame_start = r_frame_start;
        n_playing     = r_playing;
        n_mode        = r_mode;
        n_elapsed     = r_elapsed;
        if (w_fire) begin
            unique case (r_kind)
                KIND_TICK: begin
                    if (r_playing) begin
                        if (w_elapsed >= {w_dur, 8'h00}) begin
                            n_frame_now = w_step_frame;
                            n_playing   = !w_step_stop;
                            n_elapsed   = '0;
                        end else begin
                            n_elapsed   = w_elapsed;
                        end
                    end
                end
                KIND_PLAY: begin
                    n_playing = 1'b1;
                    if (r_mode == MODE_ONCE || r_mode == MODE_LOOP) begin
                        n_frame_now = r_frame_start;
                    end else begin
                        n_frame_now = FRAME_W'(w_last);
                    end
                end
                KIND_PLAY_FROM: begin
                    n_playing     = 1'b1;
                    n_frame_start = r_start_frame;
                    n_frame_now   = r_start_frame;
                end
                KIND_REVERSE: begin
                    n_playing = 1'b1;
                    n_mode    = t_mode'({~r_mode[1], r_mode[0]});
                end
                KIND_STOP: begin
                    n_playing = 1'b0;
                end
                KIND_RESUME: begin
                    n_playing = 1'b1;
                end
                default: begin
                    n_playing = r_playing;
                end
            endcase
        end
        if (i_cfg_we && i_cfg_idx == CFG_INIT_MODE) begin
            n_mode = t_mode'(i_cfg_wdata[MODE_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= FRAME_COUNT_RST;
            r_speed       <= SPEED_RST;
            r_frame_now   <= '0;
            r_frame_start <= '0;
            r_playing     <= 1'b0;
            r_mode        <= MODE_ONCE;
            r_elapsed     <= '0;
            r_dur_oob     <= 1'b0;
        end else begin
            r_frame_now   <= n_frame_now;
            r_frame_start <= n_frame_start;
            r_playing     <= n_playing;
            r_mode        <= n_mode;
            r_elapsed     <= n_elapsed;
            r_dur_oob     <= (32'(n_frame_now) >= MAX_FRAMES);
            if (i_cfg_we && i_cfg_idx == CFG_FRAME_COUNT) begin
                r_frame_count <= i_cfg_wdata[COUNT_W-1:0];
            end
            if (i_cfg_we && i_cfg_idx == CFG_SPEED) begin
                r_speed <= i_cfg_wdata[SPEED_W-1:0];
            end
        end
    end

    // look up the duration of the frame that the next request will see
    assign w_rd_addr = i_rst_n ? ADDR_W'(n_frame_now) : '0;
    assign w_wr_en   = w_fire && r_load && (32'(r_frame_index) < MAX_FRAMES);

    sfs_dur_ram #(
        .MAX_FRAMES (MAX_FRAMES),
        .ADDR_W     (ADDR_W)
    ) u_dur_ram (
        .i_clk      (i_clk),
        .i_wr_en    (w_wr_en),
        .i_wr_addr  (ADDR_W'(r_frame_index)),
        .i_wr_data  (r_frame_duration),
        .i_rd_addr  (w_rd_addr),
        .o_rd_data  (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_fire) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_frame   <= n_frame_now;
            r_out_playing <= n_playing;
            r_out_mode    <= n_mode;
            r_out_changed <= (n_frame_now != r_frame_now);
        end
    end

    assign o_rsp.valid         = r_out_vld;
    assign o_rsp.current_frame = r_out_frame;
    assign o_rsp.playing       = r_out_playing;
    assign o_rsp.mode          = r_out_mode;
    assign o_rsp.frame_changed = r_out_changed;

endmodule

`default_nettype wire

### rtl/sfs_dur_ram.sv
// Frame duration table: one write port, one registered read port with
// write-to-read forwarding. Depends on sfs_pkg.
`default_nettype none

module sfs_dur_ram #(
    parameter int MAX_FRAMES = sfs_pkg::MAX_FRAMES_DEF,
    parameter int ADDR_W     = $clog2(MAX_FRAMES)
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_wr_en,
    input  wire logic [ADDR_W-1:0]         i_wr_addr,
    input  wire logic [sfs_pkg::DUR_W-1:0] i_wr_data,
    input  wire logic [ADDR_W-1:0]         i_rd_addr,
    output logic      [sfs_pkg::DUR_W-1:0] o_rd_data
);
    import sfs_pkg::*;

    logic [DUR_W-1:0] r_mem [MAX_FRAMES];
    logic [DUR_W-1:0] r_rd_data;
    logic [DUR_W-1:0] r_fwd_data;
    logic             r_fwd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data  <= r_mem[i_rd_addr];
        r_fwd      <= i_wr_en && (i_wr_addr == i_rd_addr);
        r_fwd_data <= i_wr_data;
    end

    assign o_rd_data = r_fwd ? r_fwd_data : r_rd_data;

endmodule

`default_nettype wire

### dv/sprite_frame_sequencer_top_test.sv
// Self-checking test of sprite_frame_sequencer_top: a directed table, then random command phases
// under several register settings; responses checked against pinned values or a frame predictor.
// Depends on sfs_pkg, sfs_req_if, sfs_rsp_if and the sequencer RTL.

module sprite_frame_sequencer_top_test;
    import sfs_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 225;
    localparam int HOLD_AT      = 500;
    localparam int HOLD_CYCLES  = 400;

    localparam logic [KIND_W-1:0]    KIND_RSVD6  = 3'd6;
    localparam logic [KIND_W-1:0]    KIND_RSVD7  = 3'd7;
    localparam logic [ELAPSED_W-1:0] ELAPSED_CAP = {ELAPSED_W{1'b1}};

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [DELTA_W-1:0] delta;
        logic [FRAME_W-1:0] start_frame;
        logic               load_enable;
        logic [FRAME_W-1:0] frame_index;
        logic [DUR_W-1:0]   frame_duration;
    } t_cmd;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic               playing;
        t_mode              mode;
        logic               changed;
    } t_status;

    typedef struct {
        t_cmd    cmd;
        bit      pinned;
        t_status want;
    } t_script_row;

    localparam int SCRIPT_LEN = 21;

    t_script_row opening_rows [SCRIPT_LEN] = '{
        '{'{KIND_STOP,       16'd0,    6'd0,  1'b1, 6'd0,  16'd0},    1'b1,
          '{6'd0,  1'b0, MODE_ONCE,     1'b0}},
        '{'{KIND_TICK,       16'hFFFF, 6'd0,  1'b1, 6'd63, 16'hFFFF}, 1'b1,
          '{6'd0,  1'b0, MODE_ONCE,     1'b0}},
        '{'{KIND_RSVD7,      16'd0,    6'd0,  1'b1, 6'd62, 16'd3},    1'b1,
          '{6'd0,  1'b0, MODE_ONCE,     1'b0}},
        '{'{KIND_RSVD6,      16'hFFFF, 6'd63, 1'b0, 6'd0,  16'd0},    1'b1,
          '{6'd0,  1'b0, MODE_ONCE,     1'b0}},
        '{'{KIND_PLAY,       16'd0,    6'd0,  1'b0, 6'd0,  16'd0},    1'b1,
          '{6'd0,  1'b1, MODE_ONCE,     1'b0}},
        '{'{KIND_TICK,       16'd0,    6'd0,  1'b0, 6'd0,  16'd0},    1'b1,
          '{6'd0,  1'b0, MODE_ONCE,     1'b0}},
        '{'{KIND_RESUME,     16'd0,    6'd0,  1'b0, 6'd0,  16'd0},    1'b1,
          '{6'd0,  1'b1, MODE_ONCE,     1'b0}},
        '{'{KIND_REVERSE,    16'd0,    6'd0,  1'b0, 6'd0,  16'd0},    1'b1,
          '{6'd0,  1'b1, MODE_REV_ONCE, 1'b0}},
        '{'{KIND_TICK,       16'd0,    6'd0,  1'b0, 6'd0,  16'd0},    1'b1,
          '{6'd0,  1'b0, MODE_REV_ONCE, 1'b0}},
        '{'{KIND_PLAY_FROM,  16'd0,    6'd63, 1'b0, 6'd0,  16'd0},    1'b1,
          '{6'd63, 1'b1, MODE_REV_ONCE, 1'b1}},
        '{'{KIND_TICK,       16'hFFFE, 6'd0,  1'b1, 6'd63, 16'd0},    1'b1,
          '{6'd63, 1'b1, MODE_REV_ONCE, 1'b0}},
        '{'{KIND_TICK,       16'd0,    6'd0,  1'b0, 6'd0,  16'd0},    1'b1,
          '{6'd62, 1'b0, MODE_REV_ONCE, 1'b1}},
        '{'{KIND_REVERSE,    16'd0,    6'd0,  1'b0, 6'd0,  16'd0},    1'b1,
          '{6'd62, 1'b1, MODE_ONCE,     1'b0}},
        '{'{KIND_TICK,       16'd2,    6'd0,  1'b0, 6'd0,  16'd0},    1'b0, '0},
        '{'{KIND_TICK,       16'd1,    6'd0,  1'b0, 6'd0,  16'd0},    1'b0, '0},
        '{'{KIND_PLAY_FROM,  16'd0,    6'd1,  1'b1, 6'd1,  16'hFFFF}, 1'b0, '0},
        '{'{KIND_REVERSE,    16'd0,    6'd0,  1'b0, 6'd0,  16'd0},    1'b0, '0},
        '{'{KIND_TICK,       16'hFFFF, 6'd0,  1'b0, 6'd0,  16'd0},    1'b0, '0},
        '{'{KIND_STOP,       16'd0,    6'd0,  1'b1, 6'd0,  16'hFFFF}, 1'b0, '0},
        '{'{KIND_RESUME,     16'd0,    6'd0,  1'b0, 6'd0,  16'd0},    1'b0, '0},
        '{'{KIND_TICK,       16'hFFFF, 6'd0,  1'b0, 6'd0,  16'd0},    1'b0, '0}
    };

    int    phase_count [6] = '{64, 1, 8, 0, 127, 5};
    t_mode phase_mode  [6] = '{MODE_LOOP, MODE_REV_LOOP, MODE_REV_ONCE, MODE_ONCE,
                               MODE_LOOP, MODE_REV_LOOP};
    int    phase_speed [6] = '{256, 65535, 1, 0, 512, 128};

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    sfs_req_if req_ch ();
    sfs_rsp_if rsp_ch ();

    sprite_frame_sequencer_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    // frame predictor state
    logic [DUR_W-1:0]     pr_dur [MAX_FRAMES_DEF];
    logic [FRAME_W-1:0]   pr_frame   = '0;
    logic [FRAME_W-1:0]   pr_start   = '0;
    logic                 pr_playing = 1'b0;
    t_mode                pr_mode    = MODE_ONCE;
    logic [ELAPSED_W-1:0] pr_elapsed = '0;
    logic [COUNT_W-1:0]   cfg_count  = FRAME_COUNT_RST;
    logic [SPEED_W-1:0]   cfg_speed  = SPEED_RST;

    t_status status_q [$];
    t_status got_status;
    t_status want_status;
    int      reqs_sent  = 0;
    int      rsps_seen  = 0;
    int      fails      = 0;
    int      cycles     = 0;
    bit      send_calm  = 1'b0;
    bit      recv_calm  = 1'b0;

    function automatic int clip_len();
        int n;
        n = cfg_count;
        if (n == 0) n = 1;
        if (n > CLIP_LIMIT) n = CLIP_LIMIT;
        return n;
    endfunction

    function automatic void step_frame(input int n);
        int f;
        f = pr_frame;
        case (pr_mode)
            MODE_ONCE: begin
                if (f + 1 >= n - 1) begin
                    f = (f + 1 > n - 1) ? n - 1 : f + 1;
                    pr_playing = 1'b0;
                end else begin
                    f = f + 1;
                end
            end
            MODE_LOOP: begin
                f = (f + 1 >= n) ? int'(pr_start) : f + 1;
            end
            MODE_REV_ONCE: begin
                if (f == 0) begin
                    pr_playing = 1'b0;
                end else begin
                    f = f - 1;
                    if (f <= int'(pr_start)) pr_playing = 1'b0;
                end
            end
            default: begin
                f = (f == 0 || f - 1 < int'(pr_start)) ? n - 1 : f - 1;
            end
        endcase
        pr_frame = FRAME_W'(f);
    endfunction

    function automatic t_status predict_status(input t_cmd c);
        int                 n;
        logic [FRAME_W-1:0] was;
        logic [40:0]        sum;
        n   = clip_len();
        was = pr_frame;
        case (c.kind)
            KIND_TICK: begin
                if (pr_playing) begin
                    sum = pr_elapsed + c.delta * cfg_speed;
                    pr_elapsed = (sum > ELAPSED_CAP) ? ELAPSED_CAP : sum[ELAPSED_W-1:0];
                    if (pr_elapsed >= {pr_dur[pr_frame], 8'h00}) begin
                        step_frame(n);
                        pr_elapsed = '0;
                    end
                end
            end
            KIND_PLAY: begin
                pr_playing = 1'b1;
                if (pr_mode == MODE_ONCE || pr_mode == MODE_LOOP) pr_frame = pr_start;
                else pr_frame = FRAME_W'(n - 1);
            end
            KIND_PLAY_FROM: begin
                pr_playing = 1'b1;
                pr_start   = c.start_frame;
                pr_frame   = c.start_frame;
            end
            KIND_REVERSE: begin
                pr_playing = 1'b1;
                pr_mode    = t_mode'({~pr_mode[1], pr_mode[0]});
            end
            KIND_STOP:   pr_playing = 1'b0;
            KIND_RESUME: pr_playing = 1'b1;
            default: ;
        endcase
        if (c.load_enable) pr_dur[c.frame_index] = c.frame_duration;
        return '{pr_frame, pr_playing, pr_mode, pr_frame != was};
    endfunction

    function automatic logic [DUR_W-1:0] random_duration();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return DUR_W'($urandom_range(0, 6));
        if (roll < 90) return DUR_W'($urandom_range(0, 300));
        if (roll < 95) return {DUR_W{1'b1}};
        return DUR_W'($urandom_range(0, 65535));
    endfunction

    function automatic t_cmd random_cmd(input int n);
        t_cmd c;
        int   roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) c.delta = DELTA_W'($urandom_range(0, 15));
        else if (roll < 90) c.delta = DELTA_W'($urandom_range(0, 255));
        else c.delta = DELTA_W'($urandom_range(0, 65535));
        if ($urandom_range(0, 9) < 8) c.start_frame = FRAME_W'($urandom_range(0, n - 1));
        else c.start_frame = FRAME_W'($urandom_range(0, 63));
        c.load_enable    = ($urandom_range(0, 4) == 0);
        c.frame_index    = FRAME_W'($urandom_range(0, 63));
        c.frame_duration = random_duration();
        roll = $urandom_range(0, 99);
        if (roll < 58) c.kind = KIND_TICK;
        else if (roll < 64) c.kind = KIND_PLAY;
        else if (roll < 72) c.kind = KIND_PLAY_FROM;
        else if (roll < 78) c.kind = KIND_REVERSE;
        else if (roll < 84) c.kind = KIND_STOP;
        else if (roll < 95) c.kind = KIND_RESUME;
        else if (roll < 97) c.kind = KIND_RSVD6;
        else c.kind = KIND_RSVD7;
        return c;
    endfunction

    task automatic send_cmd(input t_cmd c, input bit pinned, input t_status want);
        int      gap;
        t_status guess;
        gap = send_calm ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.kind           <= c.kind;
        req_ch.delta          <= c.delta;
        req_ch.start_frame    <= c.start_frame;
        req_ch.load_enable    <= c.load_enable;
        req_ch.frame_index    <= c.frame_index;
        req_ch.frame_duration <= c.frame_duration;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        guess = predict_status(c);
        status_q.insert(status_q.size(), pinned ? want : guess);
        reqs_sent++;
        if (reqs_sent % 50 == 0) send_calm = ($urandom_range(0, 3) == 0);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (rsps_seen != reqs_sent) @(posedge i_clk);
    endtask

    // write all three registers back to back, then drop the enable
    task automatic write_regs(input int count, input t_mode mode, input int speed);
        cfg_we    <= 1'b1;
        cfg_idx   <= CFG_FRAME_COUNT;
        cfg_wdata <= CFG_DATA_W'(count);
        @(posedge i_clk);
        cfg_count = COUNT_W'(count);
        cfg_idx   <= CFG_INIT_MODE;
        cfg_wdata <= CFG_DATA_W'(mode);
        @(posedge i_clk);
        pr_mode   = mode;
        cfg_idx   <= CFG_SPEED;
        cfg_wdata <= CFG_DATA_W'(speed);
        @(posedge i_clk);
        cfg_speed = SPEED_W'(speed);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got_status = '{rsp_ch.current_frame, rsp_ch.playing, t_mode'(rsp_ch.mode),
                           rsp_ch.frame_changed};
            rsps_seen++;
            if (status_q.size() == 0) begin
                fails++;
                if (fails <= 10)
                    $display("unexpected status: frame %0d playing %0b mode %0d changed %0b",
                             got_status.frame, got_status.playing, got_status.mode,
                             got_status.changed);
            end else begin
                want_status = status_q.pop_front();
                if (got_status !== want_status) begin
                    fails++;
                    if (fails <= 10)
                        $display("status mismatch: want %0d/%0b/%0d/%0b got %0d/%0b/%0d/%0b",
                                 want_status.frame, want_status.playing, want_status.mode,
                                 want_status.changed, got_status.frame, got_status.playing,
                                 got_status.mode, got_status.changed);
                end
            end
        end
    end

    initial begin
        int  wait_n;
        int  taken;
        bit  held;
        taken = 0;
        held  = 1'b0;
        rsp_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (!held && taken >= HOLD_AT) begin
                held   = 1'b1;
                wait_n = HOLD_CYCLES;
            end else begin
                wait_n = recv_calm ? 0 : $urandom_range(0, 13);
            end
            if (wait_n > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (wait_n) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!rsp_ch.valid) @(posedge i_clk);
            taken++;
            if (taken % 50 == 0) recv_calm = ($urandom_range(0, 3) == 0);
        end
    end

    initial begin
        t_cmd fill;
        int   count;
        int   speed;
        t_mode mode;
        i_rst_n               <= 1'b0;
        cfg_we                <= 1'b0;
        cfg_idx               <= CFG_FRAME_COUNT;
        cfg_wdata             <= '0;
        req_ch.valid          <= 1'b0;
        req_ch.kind           <= KIND_TICK;
        req_ch.delta          <= '0;
        req_ch.start_frame    <= '0;
        req_ch.load_enable    <= 1'b0;
        req_ch.frame_index    <= '0;
        req_ch.frame_duration <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < SCRIPT_LEN; r++)
            send_cmd(opening_rows[r].cmd, opening_rows[r].pinned, opening_rows[r].want);

        // load every duration entry before random ticks can read one
        for (int e = 0; e < MAX_FRAMES_DEF; e++) begin
            fill = '{KIND_STOP, '0, '0, 1'b1, FRAME_W'(e), random_duration()};
            send_cmd(fill, 1'b0, '0);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            if (ph < 6) begin
                count = phase_count[ph];
                mode  = phase_mode[ph];
                speed = phase_speed[ph];
            end else begin
                count = $urandom_range(1, 64);
                mode  = t_mode'($urandom_range(0, 3));
                speed = $urandom_range(1, 65535);
            end
            write_regs(count, mode, speed);
            for (int k = 0; k < PHASE_ITEMS; k++)
                send_cmd(random_cmd(clip_len()), 1'b0, '0);
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (status_q.size() != 0) fails++;
        if (fails == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### sprite_frame_sequencer_top.f
rtl/sfs_pkg.sv
rtl/sfs_req_if.sv
rtl/sfs_rsp_if.sv
rtl/sfs_dur_ram.sv
rtl/sprite_frame_sequencer_top.sv
dv/sprite_frame_sequencer_top_test.sv
